>>> rtl/ccq_pkg.sv
// ----------------------------------------------------------------------------
// Color codebook quantizer package
// Shared types, widths and request codes for the quantizer and its units.
// ----------------------------------------------------------------------------
package ccq_pkg;

    // Default codebook depth and register reset value.
    localparam int          NUM_CODEWORDS_DEF = 128;
    localparam logic [7:0]  ACTIVE_RESET      = 8'd128;

    // Accumulator widths.
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 40;
    localparam int DIST_W = 48;
    localparam int PROD_W = 42;

    // Request codes.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_CLASSIFY = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;
    localparam logic [1:0] REQ_END_PASS = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  entry_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] weight;
    } req_t;

    // Result word.
    typedef struct packed {
        logic [6:0]        code_index;
        logic [7:0]        out_red;
        logic [7:0]        out_green;
        logic [7:0]        out_blue;
        logic [DIST_W-1:0] distortion;
        logic              saturated;
    } rsp_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/ccq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ccq_divider.sv
// ----------------------------------------------------------------------------
// Clamped mean divider
// Restoring divider that yields min(dividend / divisor, 255), one bit a cycle.
// ----------------------------------------------------------------------------
module ccq_divider
    import ccq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       step_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [38:0]      dsh_reg;
    logic [7:0]       quo_reg;
    logic             big;
    logic             ge;

    // A quotient of 256 or more is clamped at once.
    assign big = req.dividend >= {req.divisor, 8'b0};
    assign ge  = rem_reg >= {1'b0, dsh_reg};

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (big)
                begin
                    quo_reg  <= 8'hFF;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    rem_reg  <= req.dividend;
                    dsh_reg  <= {req.divisor, 7'b0};
                    quo_reg  <= '0;
                    step_reg <= 3'd7;
                end
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - {1'b0, dsh_reg};
                end
                quo_reg <= {quo_reg[6:0], ge};
                dsh_reg <= dsh_reg >> 1;
                if (step_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 3'd1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/color_codebook_quantizer.sv
// ----------------------------------------------------------------------------
// Color codebook quantizer
// One pass of an LBG color quantizer over an RGB codebook.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its single result word
// appears on rsp for one cycle with done high and cannot be held off. A write
// is answered straight from idle, a read from the read state. A classify scans
// the n active codewords through the codebook RAM read port, one per cycle,
// then runs four multiply and add steps on one shared multiplier. An end of
// pass visits every active codeword; one with samples goes through three
// divisions on one bit-serial divider, while an empty one is skipped.
module color_codebook_quantizer
    import ccq_pkg::*;
#(
    parameter int NUM_CODEWORDS = NUM_CODEWORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp
);

    localparam int IDX_W = $clog2(NUM_CODEWORDS);
    localparam int ACC_W = CNT_W + 3 * SUM_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD     = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_SCAN_E = 4'd3;
    localparam logic [3:0] ST_ACC_RD = 4'd4;
    localparam logic [3:0] ST_MUL_D  = 4'd5;
    localparam logic [3:0] ST_ADD_D  = 4'd6;
    localparam logic [3:0] ST_MUL_C  = 4'd7;
    localparam logic [3:0] ST_ADD_C  = 4'd8;
    localparam logic [3:0] ST_ACC_WR = 4'd9;
    localparam logic [3:0] ST_UPD_RD = 4'd10;
    localparam logic [3:0] ST_UPD_LD = 4'd11;
    localparam logic [3:0] ST_UPD_DV = 4'd12;
    localparam logic [3:0] ST_UPD_WR = 4'd13;
    localparam logic [3:0] ST_UPD_NX = 4'd14;

    logic [3:0]              state_reg;
    logic [7:0]              active_reg;
    logic                    done_reg;
    rsp_t                    rsp_reg;
    req_t                    req_reg;
    logic [NUM_CODEWORDS-1:0] cb_valid_reg;
    logic [NUM_CODEWORDS-1:0] acc_valid_reg;
    logic                    rd_vld_reg;
    logic [8:0]              scan_cnt_reg;
    logic                    cmp_vld_reg;
    logic                    cmp_cbv_reg;
    logic                    cmp_first_reg;
    logic [8:0]              cmp_idx_reg;
    logic [8:0]              best_idx_reg;
    logic [17:0]             best_d_reg;
    logic [23:0]             best_col_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [1:0]              comp_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SUM_W-1:0]        sum_reg [3];
    logic [DIST_W-1:0]       pass_reg;
    logic                    ovf_reg;
    logic [DIST_W-1:0]       res_d_reg;
    logic [8:0]              upd_cnt_reg;
    logic [7:0]              mean_reg [3];
    logic                    div_start_reg;

    logic                    accept;
    logic [8:0]              idx_ext;
    logic                    in_range;
    logic [IDX_W-1:0]        req_addr;
    logic [8:0]              n_lim;
    logic [8:0]              n_last;
    logic                    cb_we;
    logic [IDX_W-1:0]        cb_waddr;
    logic [23:0]             cb_wdata;
    logic [IDX_W-1:0]        cb_raddr;
    logic [23:0]             cb_rdata;
    logic                    acc_we;
    logic [ACC_W-1:0]        acc_wdata;
    logic [IDX_W-1:0]        acc_raddr;
    logic [ACC_W-1:0]        acc_rdata;
    logic [23:0]             cmp_col;
    logic signed [8:0]       dr;
    logic signed [8:0]       dg;
    logic signed [8:0]       db;
    logic signed [17:0]      sr;
    logic signed [17:0]      sg;
    logic signed [17:0]      sb;
    logic [17:0]             sq_dist;
    logic [7:0]              req_col;
    logic [17:0]             mul_b;
    logic [DIST_W:0]         dsum;
    logic [CNT_W:0]          csum;
    logic [SUM_W:0]          ssum;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'b0, active_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            active_reg <= pwdata[7:0];
        end
    end

    // Active count clamped to 1..NUM_CODEWORDS.
    always_comb
    begin
        priority if (active_reg == 8'd0)
        begin
            n_lim = 9'd1;
        end
        else if ({1'b0, active_reg} > 9'(NUM_CODEWORDS))
        begin
            n_lim = 9'(NUM_CODEWORDS);
        end
        else
        begin
            n_lim = {1'b0, active_reg};
        end
    end
    assign n_last = n_lim - 9'd1;

    assign accept   = start && !busy;
    assign busy     = state_reg != ST_IDLE;
    assign idx_ext  = {2'b0, req.entry_index};
    assign in_range = idx_ext < 9'(NUM_CODEWORDS);
    assign req_addr = idx_ext[IDX_W-1:0];

    // Codebook memory ports.
    assign cb_we    = (accept && req.req_type == REQ_WRITE && in_range)
                      || state_reg == ST_UPD_WR;
    assign cb_waddr = (state_reg == ST_UPD_WR) ? upd_cnt_reg[IDX_W-1:0] : req_addr;
    assign cb_wdata = (state_reg == ST_UPD_WR) ?
                      {mean_reg[0], mean_reg[1], mean_reg[2]} :
                      {req.red, req.green, req.blue};
    assign cb_raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[IDX_W-1:0] : req_addr;

    ccq_ram #(.WIDTH(24), .DEPTH(NUM_CODEWORDS)) u_cb_ram (
        .clk   (clk),
        .we    (cb_we),
        .waddr (cb_waddr),
        .wdata (cb_wdata),
        .raddr (cb_raddr),
        .rdata (cb_rdata)
    );

    // Accumulator memory ports.
    assign acc_we    = state_reg == ST_ACC_WR;
    assign acc_wdata = {cnt_reg, sum_reg[0], sum_reg[1], sum_reg[2]};
    assign acc_raddr = (state_reg == ST_ACC_RD) ? best_idx_reg[IDX_W-1:0] :
                       upd_cnt_reg[IDX_W-1:0];

    ccq_ram #(.WIDTH(ACC_W), .DEPTH(NUM_CODEWORDS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (best_idx_reg[IDX_W-1:0]),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Squared distance of the sample to the codeword just read.
    assign cmp_col = cmp_cbv_reg ? cb_rdata : 24'b0;
    assign dr   = $signed({1'b0, req_reg.red})   - $signed({1'b0, cmp_col[23:16]});
    assign dg   = $signed({1'b0, req_reg.green}) - $signed({1'b0, cmp_col[15:8]});
    assign db   = $signed({1'b0, req_reg.blue})  - $signed({1'b0, cmp_col[7:0]});
    assign sr   = dr * dr;
    assign sg   = dg * dg;
    assign sb   = db * db;
    assign sq_dist = {1'b0, sr[16:0]} + {1'b0, sg[16:0]} + {1'b0, sb[16:0]};

    // Shared multiplier operand and saturating adders.
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    req_col = req_reg.red;
            2'd1:    req_col = req_reg.green;
            default: req_col = req_reg.blue;
        endcase
    end
    assign mul_b = (state_reg == ST_MUL_D) ? best_d_reg : {10'b0, req_col};
    assign dsum  = {1'b0, pass_reg} + {7'b0, prod_reg};
    assign csum  = {1'b0, cnt_reg} + {9'b0, req_reg.weight};
    assign ssum  = {1'b0, sum_reg[comp_reg]} + {1'b0, prod_reg[SUM_W-1:0]};

    // Mean divider.
    assign div_req.start    = div_start_reg;
    assign div_req.dividend = sum_reg[comp_reg];
    assign div_req.divisor  = cnt_reg;

    ccq_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            cb_valid_reg  <= '0;
            acc_valid_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            pass_reg      <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            cmp_vld_reg   <= state_reg == ST_SCAN;
            cmp_idx_reg   <= scan_cnt_reg;
            cmp_cbv_reg   <= cb_valid_reg[scan_cnt_reg[IDX_W-1:0]];

            // Running minimum, ties keep the lower index.
            if (cmp_vld_reg)
            begin
                cmp_first_reg <= 1'b0;
                if (cmp_first_reg || sq_dist < best_d_reg)
                begin
                    best_d_reg   <= sq_dist;
                    best_idx_reg <= cmp_idx_reg;
                    best_col_reg <= cmp_col;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= req;
                        unique case (req.req_type)
                            REQ_WRITE:
                            begin
                                if (in_range)
                                begin
                                    cb_valid_reg[req_addr] <= 1'b1;
                                end
                                rsp_reg  <= {req.entry_index, req.red, req.green,
                                             req.blue, {DIST_W{1'b0}}, 1'b0};
                                done_reg <= 1'b1;
                            end
                            REQ_READ:
                            begin
                                rd_vld_reg <= in_range && cb_valid_reg[req_addr];
                                state_reg  <= ST_RD;
                            end
                            REQ_CLASSIFY:
                            begin
                                scan_cnt_reg  <= '0;
                                cmp_first_reg <= 1'b1;
                                state_reg     <= ST_SCAN;
                            end
                            default:
                            begin
                                upd_cnt_reg <= '0;
                                state_reg   <= ST_UPD_RD;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    rsp_reg   <= {req_reg.entry_index, rd_vld_reg ? cb_rdata : 24'b0,
                                  {DIST_W{1'b0}}, 1'b0};
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 9'd1;
                    if (scan_cnt_reg == n_last)
                    begin
                        state_reg <= ST_SCAN_E;
                    end
                end
                ST_SCAN_E:
                begin
                    state_reg <= ST_ACC_RD;
                end
                ST_ACC_RD:
                begin
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    if (acc_valid_reg[best_idx_reg[IDX_W-1:0]])
                    begin
                        {cnt_reg, sum_reg[0], sum_reg[1], sum_reg[2]} <= acc_rdata;
                    end
                    else
                    begin
                        cnt_reg    <= '0;
                        sum_reg[0] <= '0;
                        sum_reg[1] <= '0;
                        sum_reg[2] <= '0;
                    end
                    prod_reg  <= {18'b0, req_reg.weight} * {24'b0, mul_b};
                    state_reg <= ST_ADD_D;
                end
                ST_ADD_D:
                begin
                    res_d_reg <= {{(DIST_W-PROD_W){1'b0}}, prod_reg};
                    pass_reg  <= dsum[DIST_W] ? {DIST_W{1'b1}} : dsum[DIST_W-1:0];
                    cnt_reg   <= csum[CNT_W] ? {CNT_W{1'b1}} : csum[CNT_W-1:0];
                    if (dsum[DIST_W] || csum[CNT_W])
                    begin
                        ovf_reg <= 1'b1;
                    end
                    comp_reg  <= 2'd0;
                    state_reg <= ST_MUL_C;
                end
                ST_MUL_C:
                begin
                    prod_reg  <= {18'b0, req_reg.weight} * {24'b0, mul_b};
                    state_reg <= ST_ADD_C;
                end
                ST_ADD_C:
                begin
                    sum_reg[comp_reg] <= ssum[SUM_W] ? {SUM_W{1'b1}} : ssum[SUM_W-1:0];
                    if (ssum[SUM_W])
                    begin
                        ovf_reg <= 1'b1;
                    end
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= ST_ACC_WR;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_MUL_C;
                    end
                end
                ST_ACC_WR:
                begin
                    acc_valid_reg[best_idx_reg[IDX_W-1:0]] <= 1'b1;
                    rsp_reg   <= {best_idx_reg[6:0], best_col_reg, res_d_reg, ovf_reg};
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_UPD_RD:
                begin
                    state_reg <= ST_UPD_LD;
                end
                ST_UPD_LD:
                begin
                    comp_reg <= 2'd0;
                    if (acc_valid_reg[upd_cnt_reg[IDX_W-1:0]] &&
                        acc_rdata[ACC_W-1 -: CNT_W] != '0)
                    begin
                        {cnt_reg, sum_reg[0], sum_reg[1], sum_reg[2]} <= acc_rdata;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_UPD_DV;
                    end
                    else
                    begin
                        state_reg <= ST_UPD_NX;
                    end
                end
                ST_UPD_DV:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg[comp_reg] <= div_rsp.quotient;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= ST_UPD_WR;
                        end
                        else
                        begin
                            comp_reg      <= comp_reg + 2'd1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                ST_UPD_WR:
                begin
                    cb_valid_reg[upd_cnt_reg[IDX_W-1:0]] <= 1'b1;
                    state_reg <= ST_UPD_NX;
                end
                ST_UPD_NX:
                begin
                    if (upd_cnt_reg == n_last)
                    begin
                        rsp_reg       <= {7'b0, 24'b0, pass_reg, ovf_reg};
                        done_reg      <= 1'b1;
                        acc_valid_reg <= '0;
                        pass_reg      <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        upd_cnt_reg <= upd_cnt_reg + 9'd1;
                        state_reg   <= ST_UPD_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // An accepted word other than a write keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type != REQ_WRITE |=> busy)
        else $error("non-write word did not occupy the sequencer");

    // Every result word closes a word that was in progress or just taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(accept))
        else $error("result word without a word in progress");

    // Compares only follow scan reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> state_reg == ST_SCAN || state_reg == ST_SCAN_E)
        else $error("distance compare outside the scan");

    // The divider is started only during the update pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> state_reg == ST_UPD_DV)
        else $error("divider started outside the update pass");

    // Scan index never passes the active count.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_cnt_reg <= n_last)
        else $error("scan index beyond active codewords");

endmodule
